>>> sv/xeu_pkg.sv
package xeu_pkg;

    localparam int NAME_MAX_DEF = 9;

    localparam int HEX_W = 28;
    localparam int DEC_W = 27;
    localparam int UTF8_MAX = 6;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X    = 8'h78;

    localparam logic [31:0] CP_QUOT = 32'h0000_0022;
    localparam logic [31:0] CP_AMP  = 32'h0000_0026;
    localparam logic [31:0] CP_APOS = 32'h0000_0027;
    localparam logic [31:0] CP_LT   = 32'h0000_003C;
    localparam logic [31:0] CP_GT   = 32'h0000_003E;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (is_dec(c)) begin
            v = c - 8'h30;
        end else if (c >= 8'h61) begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    // Number of UTF-8 bytes for a code point (extended form, up to 32 bits)
    function automatic logic [2:0] utf8_len(input logic [31:0] c);
        if (c < 32'h80) begin
            return 3'd1;
        end else if (c < 32'h800) begin
            return 3'd2;
        end else if (c < 32'h1_0000) begin
            return 3'd3;
        end else if (c < 32'h20_0000) begin
            return 3'd4;
        end else if (c < 32'h400_0000) begin
            return 3'd5;
        end else begin
            return 3'd6;
        end
    endfunction

    // UTF-8 bytes, first byte in bits [7:0]
    function automatic logic [8*UTF8_MAX-1:0] utf8_bytes(input logic [31:0] c);
        logic [8*UTF8_MAX-1:0] r;
        r = '0;
        case (utf8_len(c))
            3'd1: begin
                r[7:0] = c[7:0];
            end
            3'd2: begin
                r[15:0] = {2'b10, c[5:0], 3'b110, c[10:6]};
            end
            3'd3: begin
                r[23:0] = {2'b10, c[5:0], 2'b10, c[11:6], 4'b1110, c[15:12]};
            end
            3'd4: begin
                r[31:0] = {2'b10, c[5:0], 2'b10, c[11:6], 2'b10, c[17:12],
                           5'b11110, c[20:18]};
            end
            3'd5: begin
                r[39:0] = {2'b10, c[5:0], 2'b10, c[11:6], 2'b10, c[17:12],
                           2'b10, c[23:18], 6'b111110, c[25:24]};
            end
            default: begin
                r[47:0] = {2'b10, c[5:0], 2'b10, c[11:6], 2'b10, c[17:12],
                           2'b10, c[23:18], 2'b10, c[29:24], 6'b111111, c[31:30]};
            end
        endcase
        return r;
    endfunction

endpackage

>>> sv/xeu_collect.sv
module xeu_collect #(
    parameter int NAME_MAX = xeu_pkg::NAME_MAX_DEF,
    parameter int JOB_MAX  = NAME_MAX + 2,
    parameter int JCNT_W   = $clog2(JOB_MAX + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tlast,
    input  logic                   can_load,
    output logic                   job_load,
    output logic [JOB_MAX*8-1:0]   job_bytes,
    output logic [JCNT_W-1:0]      job_cnt,
    output logic                   job_end
);
    import xeu_pkg::*;

    localparam int CNT_W = $clog2(NAME_MAX + 1);
    localparam int JOB_W = JOB_MAX * 8;

    logic             collecting_reg, collecting_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       name_reg [NAME_MAX];
    logic [HEX_W-1:0] hex_reg;
    logic [DEC_W-1:0] dec_reg;
    logic             hex_run_reg;
    logic             dec_run_reg;

    logic             accept;
    logic             store;
    logic             is_amp;
    logic             is_semi;
    logic             room;
    logic [JOB_W-1:0] raw_bytes;
    logic             named;
    logic             numeric;
    logic [31:0]      cp;

    assign s_tready = can_load;
    assign accept   = s_tvalid && s_tready;
    assign is_amp   = (s_tdata == CH_AMP);
    assign is_semi  = (s_tdata == CH_SEMI);
    assign room     = (count_reg < CNT_W'(NAME_MAX));
    assign store    = accept && collecting_reg && !is_semi && !s_tlast && !is_amp && room;
    assign job_end  = s_tlast;

    // '&', the name bytes, then the current byte in the slot after them
    always_comb begin
        raw_bytes = '0;
        for (int j = 0; j < JOB_MAX; j++) begin
            if (j == 0) begin
                raw_bytes[8*j +: 8] = CH_AMP;
            end else if ((j <= NAME_MAX) && ((j - 1) < int'(count_reg))) begin
                raw_bytes[8*j +: 8] = name_reg[((j >= 1) && (j <= NAME_MAX)) ? j - 1 : 0];
            end else begin
                raw_bytes[8*j +: 8] = s_tdata;
            end
        end
    end

    always_comb begin
        named   = 1'b1;
        numeric = 1'b0;
        cp      = '0;
        if ((count_reg == CNT_W'(4)) &&
            ({name_reg[0], name_reg[1], name_reg[2], name_reg[3]} == "quot")) begin
            cp = CP_QUOT;
        end else if ((count_reg == CNT_W'(3)) &&
                     ({name_reg[0], name_reg[1], name_reg[2]} == "amp")) begin
            cp = CP_AMP;
        end else if ((count_reg == CNT_W'(4)) &&
                     ({name_reg[0], name_reg[1], name_reg[2], name_reg[3]} == "apos")) begin
            cp = CP_APOS;
        end else if ((count_reg == CNT_W'(2)) && ({name_reg[0], name_reg[1]} == "lt")) begin
            cp = CP_LT;
        end else if ((count_reg == CNT_W'(2)) && ({name_reg[0], name_reg[1]} == "gt")) begin
            cp = CP_GT;
        end else if ((count_reg >= CNT_W'(2)) && (name_reg[0] == CH_HASH) &&
                     (name_reg[1] == CH_X)) begin
            numeric = 1'b1;
            cp      = 32'(hex_reg);
        end else if ((count_reg >= CNT_W'(1)) && (name_reg[0] == CH_HASH)) begin
            numeric = 1'b1;
            cp      = 32'(dec_reg);
        end else begin
            named = 1'b0;
        end
    end

    always_comb begin
        collecting_next = collecting_reg;
        count_next      = count_reg;
        job_load        = 1'b0;
        job_bytes       = raw_bytes;
        job_cnt         = JCNT_W'(count_reg) + JCNT_W'(2);
        if (accept) begin
            if (!collecting_reg) begin
                if (is_amp && !s_tlast) begin
                    collecting_next = 1'b1;
                    count_next      = '0;
                end else begin
                    job_load  = 1'b1;
                    job_bytes = JOB_W'(s_tdata);
                    job_cnt   = JCNT_W'(1);
                end
            end else if (is_semi) begin
                collecting_next = 1'b0;
                job_load        = 1'b1;
                if (named || numeric) begin
                    job_bytes = JOB_W'(utf8_bytes(cp));
                    job_cnt   = JCNT_W'(utf8_len(cp));
                end
            end else if (s_tlast) begin
                collecting_next = 1'b0;
                job_load        = 1'b1;
            end else if (is_amp) begin
                // flush the name without the new '&' and restart
                job_load   = 1'b1;
                job_cnt    = JCNT_W'(count_reg) + JCNT_W'(1);
                count_next = '0;
            end else if (room) begin
                count_next = count_reg + CNT_W'(1);
            end else begin
                collecting_next = 1'b0;
                job_load        = 1'b1;
            end
            if (s_tlast) begin
                collecting_next = 1'b0;
                count_next      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            count_reg      <= '0;
            hex_reg        <= '0;
            dec_reg        <= '0;
            hex_run_reg    <= 1'b0;
            dec_run_reg    <= 1'b0;
        end else begin
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
            if (store) begin
                if (count_reg == '0) begin
                    hex_reg     <= '0;
                    dec_reg     <= '0;
                    hex_run_reg <= 1'b0;
                    dec_run_reg <= (s_tdata == CH_HASH);
                end else begin
                    if (count_reg == CNT_W'(1)) begin
                        hex_run_reg <= (name_reg[0] == CH_HASH) && (s_tdata == CH_X);
                    end else if (hex_run_reg && is_hex(s_tdata)) begin
                        hex_reg <= {hex_reg[HEX_W-5:0], hex_val(s_tdata)};
                    end else begin
                        hex_run_reg <= 1'b0;
                    end
                    if (dec_run_reg && is_dec(s_tdata)) begin
                        dec_reg <= (dec_reg << 3) + (dec_reg << 1) +
                                   DEC_W'(s_tdata - 8'h30);
                    end else begin
                        dec_run_reg <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NAME_MAX; i++) begin
            if (store && (count_reg == CNT_W'(i))) begin
                name_reg[i] <= s_tdata;
            end
        end
    end

endmodule

>>> sv/xeu_emit.sv
module xeu_emit #(
    parameter int JOB_MAX = xeu_pkg::NAME_MAX_DEF + 2,
    parameter int JCNT_W  = $clog2(JOB_MAX + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   job_load,
    input  logic [JOB_MAX*8-1:0]   job_bytes,
    input  logic [JCNT_W-1:0]      job_cnt,
    input  logic                   job_end,
    output logic                   can_load,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);
    import xeu_pkg::*;

    logic                 busy_reg;
    logic [JCNT_W-1:0]    rem_reg;
    logic [JOB_MAX*8-1:0] bytes_reg;
    logic                 end_reg;
    logic                 xfer;

    assign xfer     = m_tvalid && m_tready;
    assign m_tvalid = busy_reg;
    assign m_tdata  = bytes_reg[7:0];
    assign m_tlast  = busy_reg && (rem_reg == JCNT_W'(1));
    assign m_tuser  = end_reg && m_tlast;
    assign can_load = !busy_reg || (m_tready && (rem_reg == JCNT_W'(1)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rem_reg  <= '0;
        end else if (job_load) begin
            busy_reg <= 1'b1;
            rem_reg  <= job_cnt;
        end else if (xfer) begin
            busy_reg <= (rem_reg != JCNT_W'(1));
            rem_reg  <= rem_reg - JCNT_W'(1);
        end
    end

    // advance one byte per transfer
    always_ff @(posedge aclk) begin
        if (job_load) begin
            bytes_reg <= job_bytes;
            end_reg   <= job_end;
        end else if (xfer) begin
            bytes_reg <= bytes_reg >> 8;
        end
    end

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        job_load |-> can_load)
        else $error("job loaded over a pending run");
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rem_reg != '0) && (rem_reg <= JCNT_W'(JOB_MAX)))
        else $error("remaining byte count out of range");
    a_load_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        job_load |-> (job_cnt != '0) && (job_cnt <= JCNT_W'(JOB_MAX)))
        else $error("job with bad length");
    a_run_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (xfer && m_tlast && !job_load) |=> !busy_reg)
        else $error("run continues after its last byte");
`endif

endmodule

>>> sv/xml_entity_unescape.sv
// XML entity decoder: a byte stream passes through unchanged apart from references
// "&name;", which are replaced by their UTF-8 encoding (quot, amp, apos, lt, gt,
// "#x" hex and "#" decimal character references; no digits gives byte 0x00).
// Unknown names, names longer than NAME_MAX bytes, a name cut by a new '&' and a
// name cut by the end of the stream come out verbatim. Each input transfer
// causes 0 to NAME_MAX+2 output transfers; m_tlast marks the last byte caused by
// one input and m_tuser the final byte of the stream. An input transfer is taken
// only while no run is held for output, or in the cycle the last byte of the held
// run leaves; s_tready follows m_tready on that last byte. An input that causes
// output bytes holds further input until the last of them leaves; one that causes
// none does not, so name bytes pass at one per cycle once any held run has left.
// Output stalls hold the input for as long as the held run waits. The output
// serialiser loads a whole run at once and moves one byte per transfer.
module xml_entity_unescape #(
    parameter int NAME_MAX = xeu_pkg::NAME_MAX_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // [0] stream_end
);
    import xeu_pkg::*;

    // '&', every name byte and the terminating byte
    localparam int JOB_MAX = NAME_MAX + 2;
    localparam int JCNT_W  = $clog2(JOB_MAX + 1);

    logic                 can_load;
    logic                 job_load;
    logic [JOB_MAX*8-1:0] job_bytes;
    logic [JCNT_W-1:0]    job_cnt;
    logic                 job_end;

    // Name collection, digit accumulation and decode into a run of bytes
    xeu_collect #(
        .NAME_MAX (NAME_MAX),
        .JOB_MAX  (JOB_MAX),
        .JCNT_W   (JCNT_W)
    ) u_collect (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .can_load  (can_load),
        .job_load  (job_load),
        .job_bytes (job_bytes),
        .job_cnt   (job_cnt),
        .job_end   (job_end)
    );

    // Result register: hold the run and drain it one byte per transfer
    xeu_emit #(
        .JOB_MAX (JOB_MAX),
        .JCNT_W  (JCNT_W)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_load  (job_load),
        .job_bytes (job_bytes),
        .job_cnt   (job_cnt),
        .job_end   (job_end),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

>>> tb/sv/xml_entity_unescape_tb.sv
module xml_entity_unescape_tb;

    import xeu_pkg::*;

    localparam int NAME_LEN = NAME_MAX_DEF;
    localparam int RANDOM_ITEMS = 360;

    // One byte of input text and the flag that ends the stream
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_byte_t;

    // One expected output transfer
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       stream_end;
    } out_byte_t;

    // Shapes of text fragment used by the random part
    typedef enum int {
        TK_NAMED,
        TK_HEX,
        TK_DEC,
        TK_HEX_JUNK,
        TK_UNKNOWN,
        TK_LONG,
        TK_AMP_BREAK,
        TK_END_CUT,
        TK_PLAIN
    } text_kind_e;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] in_byte
    logic       s_tlast;   // in_last
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic       m_tlast;   // run_last
    logic       m_tuser;   // [0] stream_end

    xml_entity_unescape dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------
    // Scoreboard: decodes each accepted input byte itself and holds the
    // output bytes that must follow, oldest first.
    // ------------------------------------------------------------------
    class entity_decode_scoreboard;
        bit          in_name;
        logic [7:0]  name_buf [NAME_LEN];
        int unsigned name_len;
        logic [27:0] last_hex;
        logic [26:0] last_dec;
        logic [7:0]  run_bytes [$];
        out_byte_t   expected_out [$];
        int unsigned errors;
        int unsigned inputs_seen;
        int unsigned results_seen;
        int unsigned refs_resolved;
        int unsigned verbatim_names;

        function new();
            in_name  = 0;
            name_len = 0;
            last_hex = '0;
            last_dec = '0;
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return -1;
        endfunction

        function bit name_matches(string s);
            if (name_len != s.len()) return 0;
            for (int i = 0; i < s.len(); i++)
                if (name_buf[i] != s[i]) return 0;
            return 1;
        endfunction

        // Extended UTF-8: up to six bytes, lead byte carries the length
        function void put_utf8(logic [31:0] cp);
            int n;
            logic [7:0] lead;
            if (cp < 32'h80)             n = 1;
            else if (cp < 32'h800)       n = 2;
            else if (cp < 32'h1_0000)    n = 3;
            else if (cp < 32'h20_0000)   n = 4;
            else if (cp < 32'h400_0000)  n = 5;
            else                         n = 6;
            lead = (n == 1) ? 8'h00 : 8'(8'hFF << (8 - n));
            run_bytes.push_back(lead | 8'(cp >> (6 * (n - 1))));
            for (int k = n - 1; k > 0; k--)
                run_bytes.push_back(8'h80 | 8'((cp >> (6 * (k - 1))) & 32'h3F));
            refs_resolved++;
        endfunction

        function void put_raw_name();
            run_bytes.push_back(CH_AMP);
            for (int i = 0; i < name_len; i++)
                run_bytes.push_back(name_buf[i]);
            verbatim_names++;
        endfunction

        // Resolve a name closed by ';'
        function void resolve_name();
            logic [31:0] v;
            int d;
            v = '0;
            if (name_matches("quot"))      put_utf8(CP_QUOT);
            else if (name_matches("amp"))  put_utf8(CP_AMP);
            else if (name_matches("apos")) put_utf8(CP_APOS);
            else if (name_matches("lt"))   put_utf8(CP_LT);
            else if (name_matches("gt"))   put_utf8(CP_GT);
            else if (name_len >= 2 && name_buf[0] == CH_HASH && name_buf[1] == CH_X) begin
                // leading hex digits only, the rest of the name is ignored
                for (int i = 2; i < name_len; i++) begin
                    d = hex_digit(name_buf[i]);
                    if (d < 0) break;
                    v = ((v << 4) | 32'(d)) & 32'h0FFF_FFFF;
                end
                last_hex = v[27:0];
                put_utf8(v);
            end else if (name_len >= 1 && name_buf[0] == CH_HASH) begin
                for (int i = 1; i < name_len; i++) begin
                    if (name_buf[i] < "0" || name_buf[i] > "9") break;
                    v = (v * 10 + 32'(name_buf[i] - "0")) & 32'h07FF_FFFF;
                end
                last_dec = v[26:0];
                put_utf8(v);
            end else begin
                put_raw_name();
                run_bytes.push_back(CH_SEMI);
            end
        endfunction

        // Note one accepted input byte and queue the output it causes
        function void note_input(logic [7:0] b, logic last);
            int n;
            inputs_seen++;
            run_bytes.delete();
            if (!in_name) begin
                if (b == CH_AMP && !last) begin
                    in_name  = 1;
                    name_len = 0;
                end else begin
                    run_bytes.push_back(b);
                end
            end else if (b == CH_SEMI) begin
                resolve_name();
                in_name = 0;
            end else if (last) begin
                put_raw_name();
                run_bytes.push_back(b);
                in_name = 0;
            end else if (b == CH_AMP) begin
                put_raw_name();
                name_len = 0;
            end else if (name_len < NAME_LEN) begin
                name_buf[name_len] = b;
                name_len++;
            end else begin
                put_raw_name();
                run_bytes.push_back(b);
                in_name = 0;
            end
            if (last) begin
                in_name  = 0;
                name_len = 0;
            end
            n = run_bytes.size();
            for (int i = 0; i < n; i++)
                expected_out.push_back('{run_bytes[i], i == n - 1, last && i == n - 1});
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_output(logic [7:0] data, logic run_end, logic stream_end);
            out_byte_t want;
            results_seen++;
            if (expected_out.size() == 0) begin
                report($sformatf("output byte %02h with nothing expected", data));
                return;
            end
            want = expected_out.pop_front();
            if (data !== want.data)
                report($sformatf("byte %02h, expected %02h", data, want.data));
            if (run_end !== want.run_end)
                report($sformatf("m_tlast %b, expected %b (byte %02h)",
                                 run_end, want.run_end, want.data));
            if (stream_end !== want.stream_end)
                report($sformatf("m_tuser %b, expected %b (byte %02h)",
                                 stream_end, want.stream_end, want.data));
        endtask

        function int pending();
            return expected_out.size();
        endfunction
    endclass

    entity_decode_scoreboard decode_sb;
    text_byte_t              text_q [$];
    int unsigned             cycle_no;
    int                      ready_mode;
    int                      ready_hold;

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Abort a run that hangs; a correct run needs a small fraction of this
    initial begin
        #2_000_000;
        $display("FAIL xml_entity_unescape");
        $finish;
    end

    // ------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------
    function automatic void put(logic [7:0] b, logic last = 1'b0);
        text_q.push_back('{b, last});
    endfunction

    function automatic void put_str(string s);
        foreach (s[i]) put(s[i]);
    endfunction

    // A name byte that neither closes the name nor opens a new one;
    // zero bytes turn up now and then
    function automatic logic [7:0] name_noise();
        logic [7:0] r;
        if ($urandom_range(0, 5) == 0) return 8'h00;
        do r = 8'($urandom_range(0, 255)); while (r == CH_SEMI || r == CH_AMP);
        return r;
    endfunction

    function automatic logic [7:0] hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    // Append one random fragment of text
    function automatic void put_fragment();
        string      names [5];
        text_kind_e kind;
        int         n;
        names = '{"quot", "amp", "apos", "lt", "gt"};
        kind  = text_kind_e'($urandom_range(0, TK_PLAIN));
        if ($urandom_range(0, 3) == 0) kind = TK_NAMED;
        case (kind)
            TK_NAMED: begin
                put_str({"&", names[$urandom_range(0, 4)], ";"});
            end
            TK_HEX: begin
                put_str("&#x");
                n = $urandom_range(0, NAME_LEN - 2);
                repeat (n) put(hex_char());
                put(CH_SEMI);
            end
            TK_DEC: begin
                put_str("&#");
                n = $urandom_range(0, NAME_LEN - 1);
                repeat (n) put(8'("0" + $urandom_range(0, 9)));
                put(CH_SEMI);
            end
            TK_HEX_JUNK: begin
                // digits stop at the first non-digit; an upper-case X makes it decimal
                put_str($urandom_range(0, 3) == 0 ? "&#X" : "&#x");
                n = $urandom_range(0, NAME_LEN - 4);
                repeat (n) put(hex_char());
                put(name_noise());
                put(CH_SEMI);
            end
            TK_UNKNOWN: begin
                put(CH_AMP);
                n = $urandom_range(1, NAME_LEN);
                repeat (n) put(name_noise());
                put(CH_SEMI);
            end
            TK_LONG: begin
                put(CH_AMP);
                repeat (NAME_LEN + 1) put(name_noise());
            end
            TK_AMP_BREAK: begin
                put(CH_AMP);
                n = $urandom_range(0, NAME_LEN);
                repeat (n) put(name_noise());
                put(CH_AMP);
            end
            TK_END_CUT: begin
                // end of stream, inside a name or outside one
                if ($urandom_range(0, 3) != 0) put(CH_AMP);
                n = $urandom_range(0, NAME_LEN + 1);
                repeat (n) put(name_noise());
                put(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
                n = $urandom_range(1, 6);
                repeat (n) put(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length, gaps between them, and stretches
    // where the gaps are switched off
    // ------------------------------------------------------------------
    task automatic drive_text();
        int burst_left;
        int gap;
        bit gaps_on;
        burst_left = 0;
        gaps_on    = 1;
        foreach (text_q[i]) begin
            if (burst_left == 0) begin
                gap = gaps_on ? $urandom_range(0, 5) : 0;
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 24);
                gaps_on    = $urandom_range(0, 3) != 0;
            end
            s_tvalid <= 1'b1;
            s_tdata  <= text_q[i].data;
            s_tlast  <= text_q[i].last;
            // hold the transfer until the block takes it
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            burst_left--;
        end
        s_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, chosen at random and switched
    // between always ready, coin toss, a fixed rhythm and rarely ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_no++;
        if (ready_hold == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = $urandom_range(50, 300);
        end else begin
            ready_hold--;
        end
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1) == 1;
            2:       m_tready <= (cycle_no % 5) != 0 && (cycle_no % 7) != 3;
            default: m_tready <= $urandom_range(0, 3) == 0;
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: note each input transfer, check each output transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                decode_sb.note_input(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                decode_sb.check_output(m_tdata, m_tlast, m_tuser);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int waited;
        decode_sb  = new();
        cycle_no   = 0;
        ready_mode = 0;
        ready_hold = 0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        m_tready <= 1'b0;
        aresetn  <= 1'b0;

        // Directed text: extreme plain bytes, a named reference, the
        // longest hex reference (six-byte output), an empty name, a name
        // cut by a new '&' whose follower has no digits, and a lone '&'
        // ending the stream
        put(8'h00);
        put(8'hFF);
        put_str("&lt;");
        put_str("&#xFFFFFFF;");
        put_str("&;");
        put_str("&q&");
        put_str("#;");
        put(CH_AMP, 1'b1);

        // Random text: references with random content, broken names and plain bytes
        while (text_q.size() < 25 + RANDOM_ITEMS) put_fragment();
        // close the stream so no name is left open
        put(8'($urandom_range(0, 255)), 1'b1);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        drive_text();

        // Drain: wait for every expected byte, then watch a little longer
        // for anything extra
        waited = 0;
        while (decode_sb.pending() > 0 && waited < 100_000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (32) @(posedge aclk);
        if (decode_sb.pending() > 0)
            decode_sb.report($sformatf("%0d expected bytes never arrived",
                                       decode_sb.pending()));

        $display("run covered %0d input transfers and %0d output transfers",
                 decode_sb.inputs_seen, decode_sb.results_seen);
        $display("%0d references resolved, %0d names passed through verbatim",
                 decode_sb.refs_resolved, decode_sb.verbatim_names);
        if (decode_sb.errors == 0)
            $display("PASS xml_entity_unescape");
        else
            $display("FAIL xml_entity_unescape");
        $finish;
    end

endmodule
